FILE: sv/gnss_binary_ack_deframer_assert.svh
// ----------------------------------------------------------------------------
// gnss_binary_ack_deframer assertion macros
// Concurrent check wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef GNSS_BINARY_ACK_DEFRAMER_ASSERT_SVH
`define GNSS_BINARY_ACK_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GBAD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbad assertion failed");

// next-cycle implication
`define GBAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbad assertion failed");

`else

`define GBAD_ASSERT_IMPL(lbl, ante, cons)
`define GBAD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: sv/gbad_pkg.sv
// ----------------------------------------------------------------------------
// gbad_pkg
// Constants for the binary acknowledgement deframer.
// ----------------------------------------------------------------------------
package gbad_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int FC_W            = $clog2(MAX_FRAME_BYTES + 1);
  // 6 + 16-bit length + 2 still fits
  localparam int BODY_W          = 17;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] ACK_CLASS   = 8'h05;
  localparam logic [7:0] ACK_ID_ACK  = 8'h01;
  localparam logic [7:0] ACK_ID_NAK  = 8'h00;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CLASS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID    = 1'b1;

  // byte positions within a frame
  localparam logic [FC_W-1:0] POS_HUNT    = FC_W'(0);
  localparam logic [FC_W-1:0] POS_SYNC1   = FC_W'(1);
  localparam logic [FC_W-1:0] POS_CLASS   = FC_W'(2);
  localparam logic [FC_W-1:0] POS_ID      = FC_W'(3);
  localparam logic [FC_W-1:0] POS_LEN_LO  = FC_W'(4);
  localparam logic [FC_W-1:0] POS_LEN_HI  = FC_W'(5);
  localparam logic [FC_W-1:0] POS_PAY0    = FC_W'(6);
  localparam logic [FC_W-1:0] POS_PAY1    = FC_W'(7);
  localparam logic [FC_W-1:0] POS_MAX     = FC_W'(MAX_FRAME_BYTES);

endpackage

FILE: sv/gnss_binary_ack_deframer.sv
// ----------------------------------------------------------------------------
// gnss_binary_ack_deframer
// Hunts for B5 62 frames, runs a Fletcher-8 check and reports ACK/NAK
// frames that name the configured class and id.
//
//   channel  direction  signals                         payload
//   rx       in         rx_valid / rx_ready             rx_byte[7:0]
//   ack      out        ack_valid / ack_ready           acknowledged
//   cfg      in         cfg_valid / cfg_ready           cfg_index, cfg_data[7:0]
//
// One byte per cycle unless stalled. Parser state updates on the rx transfer;
// a result sits in a one-entry output register and shows up the cycle after
// its last byte. rx_ready only drops when the incoming byte would finish a
// matching frame while the output register is still held. Synchronous reset
// clears the parser to hunting, config registers to zero and output to empty.
// ----------------------------------------------------------------------------
`include "gnss_binary_ack_deframer_assert.svh"

module gnss_binary_ack_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rx_valid,
  output logic                          rx_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          ack_valid,
  input  logic                          ack_ready,
  output logic                          acknowledged,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import gbad_pkg::*;

  logic [7:0]        expected_class;
  logic [7:0]        expected_id;

  logic [FC_W-1:0]   frame_count, frame_count_next;
  logic [7:0]        seen_class, seen_class_next;
  logic [7:0]        seen_id, seen_id_next;
  logic [15:0]       payload_length, payload_length_next;
  logic [7:0]        acked_class, acked_class_next;
  logic [7:0]        acked_id, acked_id_next;
  logic [7:0]        sum_a, sum_a_next;
  logic [7:0]        sum_b, sum_b_next;
  logic [7:0]        got_sum_a, got_sum_a_next;

  logic [BODY_W-1:0] body_end;
  logic [BODY_W-1:0] pos_w;
  logic              emit;
  logic              frame_ok;
  logic              rx_xfer;

  assign cfg_ready = 1'b1;
  assign rx_xfer   = rx_valid && rx_ready;
  assign rx_ready  = !ack_valid || ack_ready || !emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_class <= '0;
      expected_id    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EXPECTED_CLASS: expected_class <= cfg_data;
        REG_EXPECTED_ID:    expected_id    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos_w = BODY_W'(frame_count);

  always_comb begin
    frame_count_next    = frame_count;
    seen_class_next     = seen_class;
    seen_id_next        = seen_id;
    payload_length_next = payload_length;
    acked_class_next    = acked_class;
    acked_id_next       = acked_id;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    got_sum_a_next      = got_sum_a;
    body_end            = '0;
    frame_ok            = 1'b0;
    emit                = 1'b0;

    if (frame_count == POS_HUNT) begin
      if (rx_byte == SYNC_FIRST) frame_count_next = POS_SYNC1;
    end else if (frame_count == POS_SYNC1) begin
      if (rx_byte == SYNC_SECOND) begin
        frame_count_next = POS_CLASS;
        sum_a_next       = '0;
        sum_b_next       = '0;
      end else if (rx_byte != SYNC_FIRST) begin
        frame_count_next = POS_HUNT;  // broken sync
      end
    end else if (frame_count >= POS_MAX) begin
      frame_count_next = POS_HUNT;
    end else begin
      frame_count_next = frame_count + FC_W'(1);

      if (frame_count == POS_CLASS)  seen_class_next = rx_byte;
      if (frame_count == POS_ID)     seen_id_next = rx_byte;
      if (frame_count == POS_LEN_LO) payload_length_next[7:0] = rx_byte;
      if (frame_count == POS_LEN_HI) payload_length_next[15:8] = rx_byte;

      body_end = BODY_W'(6) + BODY_W'(payload_length_next);

      if (pos_w < body_end) begin
        if (frame_count == POS_PAY0) acked_class_next = rx_byte;
        if (frame_count == POS_PAY1) acked_id_next = rx_byte;
        sum_a_next = sum_a + rx_byte;
        sum_b_next = sum_b + sum_a_next;
      end else if (pos_w == body_end) begin
        got_sum_a_next = rx_byte;
      end

      if (frame_count_next >= POS_PAY0) begin
        if (body_end + BODY_W'(2) > BODY_W'(MAX_FRAME_BYTES)) begin
          frame_count_next = POS_HUNT;  // oversized frame
        end else if (pos_w == body_end + BODY_W'(1)) begin
          frame_count_next = POS_HUNT;
          frame_ok = (got_sum_a_next == sum_a_next) && (rx_byte == sum_b_next) &&
                     (payload_length_next == 16'd2) &&
                     (seen_class_next == ACK_CLASS) &&
                     (seen_id_next == ACK_ID_ACK || seen_id_next == ACK_ID_NAK) &&
                     (acked_class_next == expected_class) &&
                     (acked_id_next == expected_id);
          emit = frame_ok;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= POS_HUNT;
    end else if (rx_xfer) begin
      frame_count <= frame_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_class     <= '0;
      seen_id        <= '0;
      payload_length <= '0;
      acked_class    <= '0;
      acked_id       <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      got_sum_a      <= '0;
    end else if (rx_xfer) begin
      seen_class     <= seen_class_next;
      seen_id        <= seen_id_next;
      payload_length <= payload_length_next;
      acked_class    <= acked_class_next;
      acked_id       <= acked_id_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      got_sum_a      <= got_sum_a_next;
    end
  end

  // output register; a new result may load in the cycle the old one transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_valid <= 1'b0;
    end else if (rx_xfer && emit) begin
      ack_valid <= 1'b1;
    end else if (ack_ready) begin
      ack_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_xfer && emit) begin
      acknowledged <= (seen_id_next == ACK_ID_ACK);
    end
  end

  `GBAD_ASSERT_IMPL(a_fc_range, 1'b1, frame_count <= POS_MAX)
  `GBAD_ASSERT_IMPL(a_no_overwrite, ack_valid && !ack_ready, !(rx_xfer && emit))
  `GBAD_ASSERT_NEXT(a_result_hunts, rx_xfer && emit, frame_count == POS_HUNT && ack_valid)
  `GBAD_ASSERT_NEXT(a_no_spurious, (!ack_valid || ack_ready) && !(rx_xfer && emit), !ack_valid)

endmodule

FILE: bench/tb_gnss_binary_ack_deframer.sv
// ----------------------------------------------------------------------------
// tb_gnss_binary_ack_deframer
// Self-checking bench for the binary acknowledgement deframer. Bytes go in
// over the rx channel. A local deframer tracks sync, header, Fletcher-8 sums
// and the expected class/id, and queues the ACK/NAK flag of each frame that
// should match. Every ack transfer is checked against the oldest entry. The
// run has directed frames, then random traffic under several idle and stall
// mixes, with a long receiver hold-off to back the block up.
// ----------------------------------------------------------------------------
module tb_gnss_binary_ack_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import gbad_pkg::*;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 rx_valid = 1'b0;
  logic                 rx_ready;
  logic [7:0]           rx_byte = 8'h00;
  logic                 ack_valid;
  logic                 ack_ready = 1'b0;
  logic                 acknowledged;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_EXPECTED_CLASS;
  logic [7:0]           cfg_data = 8'h00;

  gnss_binary_ack_deframer uut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .ack_valid    (ack_valid),
    .ack_ready    (ack_ready),
    .acknowledged (acknowledged),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // local deframer state
  logic [FC_W-1:0] fr_pos;
  logic [7:0]      hdr_class;
  logic [7:0]      hdr_id;
  logic [15:0]     hdr_len;
  logic [7:0]      pay_class;
  logic [7:0]      pay_id;
  logic [7:0]      fl_a;
  logic [7:0]      fl_b;
  logic [7:0]      rcv_a;
  // registers read as zero after reset
  logic [7:0]      want_class = 8'h00;
  logic [7:0]      want_id = 8'h00;

  bit         ack_expected[$];
  logic [7:0] pay_buf[$];

  int err_count = 0;
  int sent_bytes = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_cnt = 0;
  int hold_len = 0;
  bit hold_started = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, plus one counted hold-off once it is requested
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      ack_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_len != 0 && !hold_started) begin
      ack_ready    <= 1'b0;
      hold_cnt     <= hold_len - 1;
      hold_started <= 1'b1;
    end else begin
      ack_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic deframe_byte(input logic [7:0] b);
    logic [FC_W-1:0]   pos;
    logic [BODY_W-1:0] body_end;
    bit                ok;
    if (fr_pos == POS_HUNT) begin
      if (b == SYNC_FIRST) fr_pos = POS_SYNC1;
    end else if (fr_pos == POS_SYNC1) begin
      if (b == SYNC_SECOND) begin
        fr_pos = POS_CLASS;
        fl_a   = 8'h00;
        fl_b   = 8'h00;
      end else if (b != SYNC_FIRST) begin
        fr_pos = POS_HUNT;
      end
    end else if (fr_pos >= POS_MAX) begin
      fr_pos = POS_HUNT;
    end else begin
      pos    = fr_pos;
      fr_pos = pos + FC_W'(1);
      case (pos)
        POS_CLASS:  hdr_class = b;
        POS_ID:     hdr_id = b;
        POS_LEN_LO: hdr_len[7:0] = b;
        POS_LEN_HI: hdr_len[15:8] = b;
        default: ;
      endcase
      body_end = BODY_W'(POS_PAY0) + BODY_W'(hdr_len);
      if (BODY_W'(pos) < body_end) begin
        if (pos == POS_PAY0) pay_class = b;
        else if (pos == POS_PAY1) pay_id = b;
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
      end else if (BODY_W'(pos) == body_end) begin
        rcv_a = b;
      end
      if (fr_pos >= POS_PAY0) begin
        // oversized length drops the frame as soon as it is known
        if (32'(body_end) + 2 > MAX_FRAME_BYTES) begin
          fr_pos = POS_HUNT;
        end else if (BODY_W'(pos) == body_end + BODY_W'(1)) begin
          ok = (rcv_a == fl_a) && (b == fl_b) && (hdr_len == 16'd2) &&
               (hdr_class == ACK_CLASS) &&
               (hdr_id == ACK_ID_ACK || hdr_id == ACK_ID_NAK) &&
               (pay_class == want_class) && (pay_id == want_id);
          fr_pos = POS_HUNT;
          if (ok) ack_expected.push_back(hdr_id == ACK_ID_ACK);
        end
      end
    end
  endtask

  // check ack transfers first: they come from bytes taken at earlier edges
  always @(posedge clk) begin
    if (rst) begin
      fr_pos     = POS_HUNT;
      hdr_class  = 8'h00;
      hdr_id     = 8'h00;
      hdr_len    = 16'h0000;
      pay_class  = 8'h00;
      pay_id     = 8'h00;
      fl_a       = 8'h00;
      fl_b       = 8'h00;
      rcv_a      = 8'h00;
    end else begin
      if (ack_valid && ack_ready) begin
        if (ack_expected.size() == 0) begin
          if (err_count < 10) $display("unexpected ack result: got %0b", acknowledged);
          err_count++;
        end else begin
          if (acknowledged !== ack_expected[0]) begin
            if (err_count < 10)
              $display("ack mismatch: expected %0b got %0b", ack_expected[0], acknowledged);
            err_count++;
          end
          void'(ack_expected.pop_front());
        end
      end
      if (rx_valid && rx_ready) deframe_byte(rx_byte);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      rx_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    sent_bytes++;
  endtask

  // sync + header + pay_buf, then the checksum pair unless header_only
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input logic [7:0] flip_a,
                            input logic [7:0] flip_b, input bit header_only);
    logic [7:0] body[$];
    logic [7:0] a;
    logic [7:0] s;
    a = 8'h00;
    s = 8'h00;
    body.push_back(cls);
    body.push_back(id);
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    foreach (pay_buf[i]) body.push_back(pay_buf[i]);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    foreach (body[i]) begin
      send_byte(body[i]);
      a = a + body[i];
      s = s + a;
    end
    if (!header_only) begin
      send_byte(a ^ flip_a);
      send_byte(s ^ flip_b);
    end
  endtask

  task automatic send_ack(input logic [7:0] id, input logic [7:0] flip_a,
                          input logic [7:0] flip_b);
    pay_buf.delete();
    pay_buf.push_back(want_class);
    pay_buf.push_back(want_id);
    send_frame(ACK_CLASS, id, 16'd2, flip_a, flip_b, 1'b0);
  endtask

  task automatic fill_payload(input int n);
    pay_buf.delete();
    repeat (n) pay_buf.push_back(8'($urandom_range(255)));
  endtask

  // drop valid, drain all expected results, then let the pipeline go quiet
  task automatic settle();
    rx_valid <= 1'b0;
    while (ack_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_EXPECTED_CLASS) want_class = val;
    else want_id = val;
  endtask

  task automatic set_expected(input logic [7:0] cls, input logic [7:0] id);
    settle();
    write_reg(REG_EXPECTED_CLASS, cls);
    write_reg(REG_EXPECTED_ID, id);
    cfg_valid <= 1'b0;
  endtask

  // registers at reset name class 0, id 0
  task automatic test_reset_config();
    send_ack(ACK_ID_ACK, 8'h00, 8'h00);
    send_ack(ACK_ID_NAK, 8'h00, 8'h00);
  endtask

  task automatic test_ack_nak();
    set_expected(8'hFF, 8'hFF);
    send_ack(ACK_ID_ACK, 8'h00, 8'h00);
    send_ack(ACK_ID_NAK, 8'h00, 8'h00);
    pay_buf.delete();
    pay_buf.push_back(want_class);
    pay_buf.push_back(want_id ^ 8'h01);
    send_frame(ACK_CLASS, ACK_ID_ACK, 16'd2, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_sync_handling();
    // repeated first sync byte, then broken sync
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_ack(ACK_ID_ACK, 8'h00, 8'h00);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_SECOND);
    send_ack(ACK_ID_NAK, 8'h00, 8'h00);
  endtask

  task automatic test_length_limits();
    pay_buf.delete();
    send_frame(ACK_CLASS, ACK_ID_ACK, 16'd0, 8'h00, 8'h00, 1'b0);
    fill_payload(MAX_FRAME_BYTES - 8);
    pay_buf[0] = want_class;
    pay_buf[1] = want_id;
    send_frame(ACK_CLASS, ACK_ID_ACK, 16'(MAX_FRAME_BYTES - 8), 8'h00, 8'h00, 1'b0);
    pay_buf.delete();
    send_frame(ACK_CLASS, ACK_ID_ACK, 16'(MAX_FRAME_BYTES - 7), 8'h00, 8'h00, 1'b1);
    send_frame(ACK_CLASS, ACK_ID_ACK, 16'hFFFF, 8'h00, 8'h00, 1'b1);
    send_ack(ACK_ID_ACK, 8'h00, 8'h00);
  endtask

  task automatic test_bad_frames();
    send_ack(ACK_ID_ACK, 8'h01, 8'h00);
    send_ack(ACK_ID_NAK, 8'h00, 8'h80);
    pay_buf.delete();
    pay_buf.push_back(want_class);
    pay_buf.push_back(want_id);
    send_frame(8'h06, ACK_ID_ACK, 16'd2, 8'h00, 8'h00, 1'b0);
    send_frame(ACK_CLASS, 8'h02, 16'd2, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic send_random_chunk();
    int         kind;
    int         n;
    logic [7:0] cls;
    logic [7:0] id;
    logic [7:0] b;
    kind = $urandom_range(99);
    id   = $urandom_range(1) ? ACK_ID_ACK : ACK_ID_NAK;
    if (kind < 55) begin
      send_ack(id, 8'h00, 8'h00);
    end else if (kind < 65) begin
      if ($urandom_range(1)) send_ack(id, 8'($urandom_range(1, 255)), 8'h00);
      else send_ack(id, 8'h00, 8'($urandom_range(1, 255)));
    end else if (kind < 73) begin
      // payload one bit away from the awaited class/id
      pay_buf.delete();
      pay_buf.push_back(want_class);
      pay_buf.push_back(want_id);
      pay_buf[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      send_frame(ACK_CLASS, id, 16'd2, 8'h00, 8'h00, 1'b0);
    end else if (kind < 87) begin
      cls = $urandom_range(1) ? ACK_CLASS : 8'($urandom_range(255));
      if ($urandom_range(1)) id = 8'($urandom_range(255));
      n = (kind < 83) ? $urandom_range(8) : $urandom_range(9, MAX_FRAME_BYTES - 8);
      fill_payload(n);
      if (n >= 2 && $urandom_range(1)) begin
        pay_buf[0] = want_class;
        pay_buf[1] = want_id;
      end
      send_frame(cls, id, 16'(n), 8'h00, 8'h00, 1'b0);
    end else if (kind < 90) begin
      pay_buf.delete();
      if ($urandom_range(1))
        send_frame(ACK_CLASS, id, 16'($urandom_range(MAX_FRAME_BYTES - 7, 300)),
                   8'h00, 8'h00, 1'b1);
      else
        send_frame(8'($urandom_range(255)), id,
                   16'($urandom_range(MAX_FRAME_BYTES - 7, 65535)), 8'h00, 8'h00, 1'b1);
    end else if (kind < 95) begin
      // cut-off frame, the next bytes land inside it
      fill_payload($urandom_range(1));
      send_frame(ACK_CLASS, id, 16'd2, 8'h00, 8'h00, 1'b1);
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        case ($urandom_range(7))
          0, 1:    b = SYNC_FIRST;
          2:       b = SYNC_SECOND;
          default: b = 8'($urandom_range(255));
        endcase
        send_byte(b);
      end
    end
  endtask

  task automatic test_random_traffic(input logic [7:0] cls, input logic [7:0] id,
                                     input int src_pct, input int sink_pct,
                                     input int nbytes);
    int start;
    set_expected(cls, id);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start = sent_bytes;
    while (sent_bytes - start < nbytes) send_random_chunk();
  endtask

  // hold the receiver off while matching frames keep coming
  task automatic test_backpressure();
    settle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_len = 300;
    repeat (6) send_ack($urandom_range(1) ? ACK_ID_ACK : ACK_ID_NAK, 8'h00, 8'h00);
    repeat (4) send_random_chunk();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_ack_nak();
    test_sync_handling();
    test_length_limits();
    test_bad_frames();

    test_random_traffic(8'($urandom_range(255)), 8'($urandom_range(255)), 0, 0, 360);
    test_random_traffic(ACK_CLASS, ACK_ID_ACK, 45, 0, 360);
    test_random_traffic(8'hFF, 8'h00, 0, 45, 360);
    test_random_traffic(8'h00, 8'hFF, 13, 13, 360);
    test_backpressure();

    settle();
    repeat (12) @(posedge clk);
    if (err_count == 0 && ack_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
